@@ sv/spv_pkg.sv @@
// shared types, codes and constants of the sample voice player
package spv_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_START   = 2'd1,
    MODE_PRODUCE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CFG_SAMPLE_LENGTH = 3'd0,
    CFG_START_SPEED   = 3'd1,
    CFG_START_VOLUME  = 3'd2,
    CFG_LOOP_TOTAL    = 3'd3,
    CFG_INTERP_ENABLE = 3'd4,
    CFG_RAMP_INTERVAL = 3'd5,
    CFG_RAMP_VOL_DLT  = 3'd6,
    CFG_RAMP_SPD_DLT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM_I,
    ST_MUL_V,
    ST_MIX,
    ST_DIV_N,
    ST_DIV_M,
    ST_RMS,
    ST_RMV,
    ST_RMT,
    ST_RFIN,
    ST_LOOP,
    ST_DIV_W,
    ST_DONE
  } state_e;

  localparam int DIV_WIDTH = 33;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_WIDTH);

  localparam logic [15:0] LOOP_FOREVER = 16'hffff;
  localparam logic [15:0] U16_MAX      = 16'hffff;
  localparam logic [16:0] NSAT_MAX     = 17'h1ffff;
  localparam logic [8:0]  FRAC_FULL    = 9'd255;
  localparam logic signed [17:0] MIX_LO = -18'sd126;
  localparam logic signed [17:0] MIX_HI = 18'sd127;

  typedef struct packed {
    logic                 start;
    logic [DIV_WIDTH-1:0] dividend;
    logic [31:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_WIDTH-1:0] quot;
    logic [31:0]          rem;
  } div_rsp_t;

  function automatic logic [15:0] clamp16(input logic signed [35:0] x);
    logic [15:0] r;
    if (x < 36'sd0) r = 16'd0;
    else if (x > $signed({20'd0, U16_MAX})) r = U16_MAX;
    else r = x[15:0];
    return r;
  endfunction

endpackage

@@ sv/spv_ram.sv @@
// generic single-write, single-read ram with registered read data
module spv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/spv_div.sv @@
// restoring divider, one quotient bit per cycle
module spv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spv_pkg::div_req_t req_i,
  output spv_pkg::div_rsp_t rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [spv_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [spv_pkg::DIV_WIDTH-1:0]    quo_q;
  logic [31:0]                      rem_q;
  logic [31:0]                      dvs_q;
  logic [32:0]                      trial;
  logic [32:0]                      diff;
  logic                             ge;

  assign trial = {rem_q, quo_q[spv_pkg::DIV_WIDTH-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= spv_pkg::DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == spv_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[spv_pkg::DIV_WIDTH-2:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == spv_pkg::DIV_CNT_W'(1) && !req_i.start) |=> done_q)
    else $error("divider missed its done pulse");

endmodule

@@ sv/sample_voice_player.sv @@
// top level of the sample playback voice: sequencer, shared multiplier, state
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    mode, load_address, load_value, mix_in
//  out      output     out_valid_o / out_stall_i  mix_out, voice_active, stopped_now
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  load, start and unused beats are taken in the idle state; a produce beat on an idle
//  voice goes straight to the result state; a playing one runs the read, multiply, sum,
//  volume and mix states on the shared multiplier; the ramp adds a divider run and the
//  update states, a falling speed ramp and a pass over the loop end a divider run each
//  reset clears control state; the sample ram holds no reset value
//  a result waiting under out_stall_i holds the block only once the next result is done
module sample_voice_player #(
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [11:0]        load_address_i,
  input  logic signed [7:0]  load_value_i,
  input  logic signed [7:0]  mix_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  mix_out_o,
  output logic               voice_active_o,
  output logic               stopped_now_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(SAMPLE_DEPTH);

  spv_pkg::state_e st_q, st_d;

  logic [12:0] slen_q;
  logic [15:0] sspd_q, svol_q, ltot_q, rvd_q, rsd_q;
  logic        interp_q;
  logic [31:0] rint_q;

  logic [23:0] pos_q;
  logic [15:0] spd_q, vol_q, loops_q;
  logic [31:0] timer_q;
  logic        playing_q;

  logic signed [7:0]  mix_q, a_q, b_q, res_q, s_q;
  logic signed [17:0] acc_q;
  logic               stop_q;
  logic [32:0]        t_q, n_q;
  logic [31:0]        r_q;
  logic [16:0]        m_q, nsat_q;
  logic               capped_q;
  logic signed [50:0] prod_q;

  logic              ov_q, va_q, sn_q;
  logic signed [7:0] mo_q;

  logic               in_acc, out_load;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_rdata;
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] prod_d;

  spv_pkg::div_req_t div_req;
  spv_pkg::div_rsp_t div_rsp;

  logic [16:0]        len, load_ext, nxt;
  logic [15:0]        pidx;
  logic [7:0]         frac;
  logic               a_ok;
  logic [8:0]         wfrac;
  logic signed [18:0] isum;
  logic signed [17:0] sv;
  logic signed [7:0]  s_sat;
  logic [32:0]        t_comb;
  logic [16:0]        dneg;
  logic signed [35:0] ssum, vsum;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;

  assign len = (slen_q == 13'd0) ? 17'd1 :
               ((17'(slen_q) > DEPTH17) ? DEPTH17 : 17'(slen_q));
  assign pidx     = pos_q[23:8];
  assign frac     = pos_q[7:0];
  assign a_ok     = 17'(pidx) < DEPTH17;
  assign nxt      = ((17'(pidx) + 17'd1) < len) ? (17'(pidx) + 17'd1) : 17'd0;
  assign load_ext = 17'(load_address_i);
  assign wfrac    = spv_pkg::FRAC_FULL - {1'b0, frac};

  assign isum = 19'(acc_q) + 19'($signed(prod_q[17:0]));
  assign sv   = 18'($signed(prod_q[24:8])) + 18'(mix_q);
  assign s_sat = (sv < spv_pkg::MIX_LO) ? 8'(spv_pkg::MIX_LO) :
                 ((sv > spv_pkg::MIX_HI) ? 8'(spv_pkg::MIX_HI) : sv[7:0]);
  assign t_comb = 33'(timer_q) + 33'(spd_q);
  assign dneg   = 17'd0 - 17'($signed(rsd_q));
  assign ssum   = $signed({20'd0, spd_q}) + $signed(prod_q[35:0]);
  assign vsum   = $signed({20'd0, vol_q}) + $signed(prod_q[35:0]);

  assign ram_we    = in_acc && (mode_i == spv_pkg::MODE_LOAD) && (load_ext < DEPTH17);
  assign ram_waddr = load_ext[AW-1:0];
  assign prod_d    = mul_a * mul_b;

  spv_ram #(
    .WIDTH(8),
    .DEPTH(SAMPLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(load_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  spv_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= spv_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d             = st_q;
    in_stall_o       = 1'b1;
    out_load         = 1'b0;
    ram_raddr        = pidx[AW-1:0];
    mul_a            = 18'sd0;
    mul_b            = 33'sd0;
    div_req.start    = 1'b0;
    div_req.dividend = t_comb;
    div_req.divisor  = rint_q;
    case (st_q)
      spv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && mode_i == spv_pkg::MODE_PRODUCE) begin
          st_d = playing_q ? spv_pkg::ST_RD_A : spv_pkg::ST_DONE;
        end
      end
      spv_pkg::ST_RD_A: st_d = spv_pkg::ST_RD_B;
      spv_pkg::ST_RD_B: begin
        ram_raddr = nxt[AW-1:0];
        st_d      = spv_pkg::ST_MUL_A;
      end
      spv_pkg::ST_MUL_A: begin
        mul_a = 18'(a_q);
        mul_b = $signed(33'(wfrac));
        st_d  = spv_pkg::ST_MUL_B;
      end
      spv_pkg::ST_MUL_B: begin
        mul_a = 18'(b_q);
        mul_b = $signed(33'(frac));
        st_d  = spv_pkg::ST_SUM_I;
      end
      spv_pkg::ST_SUM_I: st_d = spv_pkg::ST_MUL_V;
      spv_pkg::ST_MUL_V: begin
        mul_a = 18'(res_q);
        mul_b = $signed(33'(vol_q));
        st_d  = spv_pkg::ST_MIX;
      end
      spv_pkg::ST_MIX: begin
        if (rint_q == 32'd0) begin
          st_d = spv_pkg::ST_LOOP;
        end else if (spd_q == 16'd0) begin
          st_d = spv_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          st_d          = spv_pkg::ST_DIV_N;
        end
      end
      spv_pkg::ST_DIV_N: begin
        if (div_rsp.done) begin
          if (rsd_q[15]) begin
            div_req.start    = 1'b1;
            div_req.dividend = 33'(spd_q) + 33'(dneg) - 33'd1;
            div_req.divisor  = 32'(dneg);
            st_d             = spv_pkg::ST_DIV_M;
          end else begin
            st_d = spv_pkg::ST_RMS;
          end
        end
      end
      spv_pkg::ST_DIV_M: begin
        if (div_rsp.done) begin
          st_d = spv_pkg::ST_RMS;
        end
      end
      spv_pkg::ST_RMS: begin
        mul_a = $signed({1'b0, nsat_q});
        mul_b = 33'($signed(rsd_q));
        st_d  = spv_pkg::ST_RMV;
      end
      spv_pkg::ST_RMV: begin
        mul_a = $signed({1'b0, nsat_q});
        mul_b = 33'($signed(rvd_q));
        st_d  = spv_pkg::ST_RMT;
      end
      spv_pkg::ST_RMT: begin
        mul_a = $signed({1'b0, m_q});
        mul_b = $signed({1'b0, rint_q});
        st_d  = spv_pkg::ST_RFIN;
      end
      spv_pkg::ST_RFIN: begin
        st_d = (spd_q == 16'd0 || vol_q == 16'd0) ? spv_pkg::ST_DONE : spv_pkg::ST_LOOP;
      end
      spv_pkg::ST_LOOP: begin
        if (17'(pos_q[23:8]) >= len) begin
          div_req.start    = 1'b1;
          div_req.dividend = 33'(pos_q[23:8]);
          div_req.divisor  = 32'(len);
          st_d             = spv_pkg::ST_DIV_W;
        end else begin
          st_d = spv_pkg::ST_DONE;
        end
      end
      spv_pkg::ST_DIV_W: begin
        if (div_rsp.done) begin
          st_d = spv_pkg::ST_DONE;
        end
      end
      spv_pkg::ST_DONE: begin
        if (!ov_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = spv_pkg::ST_IDLE;
        end
      end
      default: st_d = spv_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slen_q   <= 13'd1;
      sspd_q   <= 16'd256;
      svol_q   <= 16'd256;
      ltot_q   <= 16'd1;
      interp_q <= 1'b0;
      rint_q   <= 32'd0;
      rvd_q    <= 16'd0;
      rsd_q    <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        spv_pkg::CFG_SAMPLE_LENGTH: slen_q   <= cfg_data_i[12:0];
        spv_pkg::CFG_START_SPEED:   sspd_q   <= cfg_data_i[15:0];
        spv_pkg::CFG_START_VOLUME:  svol_q   <= cfg_data_i[15:0];
        spv_pkg::CFG_LOOP_TOTAL:    ltot_q   <= cfg_data_i[15:0];
        spv_pkg::CFG_INTERP_ENABLE: interp_q <= cfg_data_i[0];
        spv_pkg::CFG_RAMP_INTERVAL: rint_q   <= cfg_data_i;
        spv_pkg::CFG_RAMP_VOL_DLT:  rvd_q    <= cfg_data_i[15:0];
        spv_pkg::CFG_RAMP_SPD_DLT:  rsd_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      spd_q     <= '0;
      vol_q     <= '0;
      loops_q   <= '0;
      timer_q   <= '0;
      playing_q <= 1'b0;
      stop_q    <= 1'b0;
    end else begin
      case (st_q)
        spv_pkg::ST_IDLE: begin
          stop_q <= 1'b0;
          if (in_acc && mode_i == spv_pkg::MODE_START) begin
            pos_q     <= '0;
            timer_q   <= '0;
            spd_q     <= sspd_q;
            vol_q     <= svol_q;
            loops_q   <= ltot_q;
            playing_q <= 1'b1;
          end
        end
        spv_pkg::ST_MIX: begin
          pos_q <= pos_q + 24'(spd_q);
          if (rint_q != 32'd0 && spd_q == 16'd0) begin
            stop_q <= 1'b1;
          end
        end
        spv_pkg::ST_RMV: spd_q <= spv_pkg::clamp16(ssum);
        spv_pkg::ST_RMT: vol_q <= spv_pkg::clamp16(vsum);
        spv_pkg::ST_RFIN: begin
          timer_q <= capped_q ? (t_q[31:0] - prod_q[31:0]) : r_q;
          if (spd_q == 16'd0 || vol_q == 16'd0) begin
            stop_q <= 1'b1;
          end
        end
        spv_pkg::ST_DIV_W: begin
          if (div_rsp.done) begin
            if (loops_q == spv_pkg::LOOP_FOREVER) begin
              pos_q <= {div_rsp.rem[15:0], pos_q[7:0]};
            end else if (loops_q <= div_rsp.quot[15:0]) begin
              stop_q <= 1'b1;
            end else begin
              loops_q <= loops_q - div_rsp.quot[15:0];
              pos_q   <= {div_rsp.rem[15:0], pos_q[7:0]};
            end
          end
        end
        spv_pkg::ST_DONE: begin
          if (out_load) begin
            playing_q <= playing_q && !stop_q;
          end
        end
        default: ;
      endcase
    end
  end

  // result beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  // working registers of one produce beat
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (st_q)
      spv_pkg::ST_IDLE: begin
        mix_q <= mix_in_i;
        s_q   <= mix_in_i;
      end
      spv_pkg::ST_RD_B:  a_q   <= a_ok ? $signed(ram_rdata) : 8'sd0;
      spv_pkg::ST_MUL_A: b_q   <= $signed(ram_rdata);
      spv_pkg::ST_MUL_B: acc_q <= $signed(prod_q[17:0]);
      spv_pkg::ST_SUM_I: res_q <= interp_q ? isum[15:8] : a_q;
      spv_pkg::ST_MIX: begin
        s_q <= s_sat;
        t_q <= t_comb;
      end
      spv_pkg::ST_DIV_N: begin
        if (div_rsp.done) begin
          n_q      <= div_rsp.quot;
          r_q      <= div_rsp.rem;
          capped_q <= 1'b0;
          m_q      <= '0;
          nsat_q   <= (div_rsp.quot > 33'(spv_pkg::NSAT_MAX)) ?
                      spv_pkg::NSAT_MAX : div_rsp.quot[16:0];
        end
      end
      spv_pkg::ST_DIV_M: begin
        if (div_rsp.done) begin
          m_q <= div_rsp.quot[16:0];
          if (n_q > div_rsp.quot) begin
            capped_q <= 1'b1;
            nsat_q   <= div_rsp.quot[16:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mo_q <= s_q;
      va_q <= playing_q && !stop_q;
      sn_q <= stop_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign mix_out_o      = mo_q;
  assign voice_active_o = va_q;
  assign stopped_now_o  = sn_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |=> out_valid_o)
    else $error("result beat lost at output register");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(voice_active_o && stopped_now_o))
    else $error("voice both active and stopped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req.start |-> !div_rsp.busy)
    else $error("divider reused while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == spv_pkg::MODE_START) |=> playing_q)
    else $error("start beat did not arm the voice");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench of the sample voice player with random handshake idling
module testbench;

  localparam int SAMPLE_WORDS = 4096;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RANDOM_PHASES = 18;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] mix;
    logic       active;
    logic       stopped;
  } mix_result_t;

  class voice_scoreboard;
    logic [12:0]        len_reg;
    logic [15:0]        speed_reg;
    logic [15:0]        volume_reg;
    logic [15:0]        loops_reg;
    logic               interp_reg;
    logic [31:0]        interval_reg;
    logic signed [15:0] vol_step_reg;
    logic signed [15:0] spd_step_reg;

    logic [7:0]  words [SAMPLE_WORDS];
    bit          loaded [SAMPLE_WORDS];
    logic [23:0] pos;
    logic [15:0] speed;
    logic [15:0] volume;
    logic [15:0] loops;
    logic [31:0] timer;
    bit          playing;

    mix_result_t mix_queue[$];
    int          errors;

    function new();
      len_reg = 13'd1;
      speed_reg = 16'd256;
      volume_reg = 16'd256;
      loops_reg = 16'd1;
      interp_reg = 1'b0;
      interval_reg = '0;
      vol_step_reg = '0;
      spd_step_reg = '0;
      pos = '0;
      speed = '0;
      volume = '0;
      loops = '0;
      timer = '0;
      playing = 1'b0;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_reg(spv_pkg::cfg_idx_e idx, logic [31:0] data);
      case (idx)
        spv_pkg::CFG_SAMPLE_LENGTH: len_reg = data[12:0];
        spv_pkg::CFG_START_SPEED:   speed_reg = data[15:0];
        spv_pkg::CFG_START_VOLUME:  volume_reg = data[15:0];
        spv_pkg::CFG_LOOP_TOTAL:    loops_reg = data[15:0];
        spv_pkg::CFG_INTERP_ENABLE: interp_reg = data[0];
        spv_pkg::CFG_RAMP_INTERVAL: interval_reg = data;
        spv_pkg::CFG_RAMP_VOL_DLT:  vol_step_reg = data[15:0];
        spv_pkg::CFG_RAMP_SPD_DLT:  spd_step_reg = data[15:0];
        default: ;
      endcase
    endfunction

    function int play_length();
      int l;
      l = len_reg;
      if (l == 0) l = 1;
      if (l > SAMPLE_WORDS) l = SAMPLE_WORDS;
      return l;
    endfunction

    function int sample_at(int idx);
      int v;
      v = 0;
      if (idx < SAMPLE_WORDS) v = $signed(words[idx]);
      return v;
    endfunction

    // word the next produce beat would read before it was ever loaded
    function bit missing_word(output int idx);
      int p, nxt;
      p = pos[23:8];
      nxt = (p + 1 < play_length()) ? p + 1 : 0;
      idx = -1;
      if (playing) begin
        if (p < SAMPLE_WORDS && !loaded[p]) idx = p;
        else if (!loaded[nxt]) idx = nxt;
      end
      return idx >= 0;
    endfunction

    function logic [15:0] clip_u16(longint x);
      logic [15:0] r;
      if (x < 0) r = '0;
      else if (x > longint'(spv_pkg::U16_MAX)) r = spv_pkg::U16_MAX;
      else r = x[15:0];
      return r;
    endfunction

    function void accept_beat(logic [1:0] mode, logic [11:0] addr, logic [7:0] value,
                              logic [7:0] mix);
      mix_result_t r;
      int p, frac, len, a, b, lvl, sum, mix_val;
      longint len8, cur_pos, wraps, t, n, m, ivl, ds, dv, spd, vol;
      bit stop;
      stop = 1'b0;
      mix_val = $signed(mix);
      r.mix = mix;
      r.active = 1'b0;
      r.stopped = 1'b0;
      if (mode == spv_pkg::MODE_LOAD) begin
        words[addr] = value;
        loaded[addr] = 1'b1;
        return;
      end
      if (mode == spv_pkg::MODE_START) begin
        pos = '0;
        timer = '0;
        speed = speed_reg;
        volume = volume_reg;
        loops = loops_reg;
        playing = 1'b1;
        return;
      end
      if (mode != spv_pkg::MODE_PRODUCE) return;
      if (playing) begin
        len = play_length();
        len8 = len * 256;
        p = pos[23:8];
        frac = pos[7:0];
        a = sample_at(p);
        if (interp_reg) begin
          b = sample_at((p + 1 < len) ? p + 1 : 0);
          lvl = (a * (255 - frac) + b * frac) >>> 8;
        end else begin
          lvl = a;
        end
        sum = ((lvl * int'(volume)) >>> 8) + mix_val;
        if (sum < spv_pkg::MIX_LO) sum = int'(spv_pkg::MIX_LO);
        else if (sum > spv_pkg::MIX_HI) sum = int'(spv_pkg::MIX_HI);

        pos = pos + 24'(speed);

        if (interval_reg != 0) begin
          spd = speed;
          vol = volume;
          t = timer;
          t = t + spd;
          ivl = interval_reg;
          n = t / ivl;
          ds = spd_step_reg;
          dv = vol_step_reg;
          if (spd == 0) begin
            n = 0;
          end else if (ds < 0) begin
            m = (spd - ds - 1) / (-ds);
            if (n > m) n = m;
          end
          speed = clip_u16(spd + n * ds);
          volume = clip_u16(vol + n * dv);
          timer = 32'(t - n * ivl);
          stop = (speed == 0) || (volume == 0);
        end

        cur_pos = pos;
        if (!stop && cur_pos >= len8) begin
          wraps = cur_pos / len8;
          if (loops == spv_pkg::LOOP_FOREVER) begin
            pos = 24'(cur_pos % len8);
          end else if (longint'(loops) <= wraps) begin
            if (loops > 16'd1) begin
              pos = 24'(cur_pos - (longint'(loops) - 1) * len8);
              loops = 16'd1;
            end
            stop = 1'b1;
          end else begin
            loops = loops - 16'(wraps);
            pos = 24'(cur_pos - wraps * len8);
          end
        end

        if (stop) playing = 1'b0;
        r.mix = 8'(sum);
        r.active = playing;
        r.stopped = stop;
      end
      mix_queue.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_output(logic [7:0] mix, logic active, logic stopped);
      mix_result_t r;
      if (mix_queue.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending, mix_out %0d", $signed(mix)));
        return;
      end
      r = mix_queue.pop_front();
      if (mix !== r.mix)
        report_mismatch($sformatf("mix_out %0d, expected %0d", $signed(mix), $signed(r.mix)));
      if (active !== r.active)
        report_mismatch($sformatf("voice_active %b, expected %b", active, r.active));
      if (stopped !== r.stopped)
        report_mismatch($sformatf("stopped_now %b, expected %b", stopped, r.stopped));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  logic [11:0]       load_address_i;
  logic signed [7:0] load_value_i;
  logic signed [7:0] mix_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [7:0] mix_out_o;
  logic              voice_active_o;
  logic              stopped_now_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [31:0]       cfg_data_i;

  voice_scoreboard voice;
  int items_sent;
  int src_idle_pct;
  int sink_idle_pct;
  bit quiet_run;
  bit hold_off_req;

  sample_voice_player #(
    .SAMPLE_DEPTH(SAMPLE_WORDS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .mode_i(mode_i),
    .load_address_i(load_address_i),
    .load_value_i(load_value_i),
    .mix_in_i(mix_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .mix_out_o(mix_out_o),
    .voice_active_o(voice_active_o),
    .stopped_now_o(stopped_now_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("[sample_voice_player] ERROR");
    $finish;
  end

  // output stall: random short bursts, plus one long hold-off on request
  initial begin
    int burst, hold_left;
    bit stall;
    burst = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        stall = 1'b1;
      end else if (!quiet_run && $urandom_range(0, 99) < sink_idle_pct) begin
        burst = $urandom_range(1, 3) - 1;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall_i <= stall;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      voice.check_output(mix_out_o, voice_active_o, stopped_now_o);
  end

  task automatic send_beat(input logic [1:0] mode, input logic [11:0] addr,
                           input logic [7:0] value, input logic [7:0] mix);
    int gap;
    gap = 0;
    if (!quiet_run && $urandom_range(0, 99) < src_idle_pct) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    load_address_i <= addr;
    load_value_i <= value;
    mix_in_i <= mix;
    do @(posedge clk_i); while (in_stall_o);
    voice.accept_beat(mode, addr, value, mix);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_other(input logic [1:0] mode);
    send_beat(mode, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // load any sample word the next produce beat reads before it was written
  task automatic send_produce(input logic [7:0] mix);
    int idx;
    while (voice.missing_word(idx))
      send_beat(spv_pkg::MODE_LOAD, 12'(idx), 8'($urandom), 8'($urandom));
    send_beat(spv_pkg::MODE_PRODUCE, 12'($urandom), 8'($urandom), mix);
  endtask

  task automatic write_cfg(input spv_pkg::cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    voice.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (voice.mix_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // extreme: -1 random, 0 low end, 1 high end
  function automatic logic [31:0] pick_setting(input int idx, input int extreme);
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    case (spv_pkg::cfg_idx_e'(idx))
      spv_pkg::CFG_SAMPLE_LENGTH: begin
        if (extreme >= 0) v = extreme ? 32'd8191 : 32'd0;
        else if (r == 0) v = 32'd4096;
        else if (r == 1) v = 32'd1;
        else if (r == 2) v = $urandom_range(17, 8191);
        else v = $urandom_range(2, 16);
      end
      spv_pkg::CFG_START_SPEED, spv_pkg::CFG_START_VOLUME: begin
        if (extreme >= 0) v = extreme ? 32'hffff : 32'd0;
        else if (r < 2) v = 32'(16'($urandom));
        else v = $urandom_range(32, 600);
      end
      spv_pkg::CFG_LOOP_TOTAL: begin
        if (extreme >= 0) v = extreme ? 32'(spv_pkg::LOOP_FOREVER) : 32'd0;
        else if (r < 2) v = 32'(spv_pkg::LOOP_FOREVER);
        else if (r == 2) v = 32'(16'($urandom));
        else v = $urandom_range(1, 5);
      end
      spv_pkg::CFG_INTERP_ENABLE: begin
        if (extreme >= 0) v = 32'(extreme);
        else v = $urandom_range(0, 1);
      end
      spv_pkg::CFG_RAMP_INTERVAL: begin
        if (extreme >= 0) v = extreme ? 32'hffff_ffff : 32'd0;
        else if (r < 5) v = 32'd0;
        else if (r == 5) v = 32'd1;
        else if (r == 6) v = $urandom;
        else v = $urandom_range(128, 4096);
      end
      default: begin
        if (extreme >= 0) v = extreme ? 32'h7fff : 32'h8000;
        else if (r < 2) v = 32'(16'($urandom));
        else v = 32'(16'($urandom_range(0, 128) - 64));
      end
    endcase
    return v;
  endfunction

  task automatic run_phase(input int budget, input bit squeeze);
    int goal, r;
    goal = items_sent + budget;
    send_other(spv_pkg::MODE_START);
    if (squeeze) hold_off_req = 1'b1;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (!voice.playing && r < 50) send_other(spv_pkg::MODE_START);
      else if (r < 80) send_produce(8'($urandom));
      else if (r < 88) send_other(spv_pkg::MODE_LOAD);
      else if (r < 92) send_other(spv_pkg::MODE_START);
      else if (r < 95) send_other(MODE_UNUSED);
      else send_produce(r[0] ? 8'h7f : 8'h80);
    end
  endtask

  initial begin
    voice = new();
    items_sent = 0;
    src_idle_pct = 20;
    sink_idle_pct = 20;
    quiet_run = 1'b0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = spv_pkg::MODE_LOAD;
    load_address_i = '0;
    load_value_i = '0;
    mix_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = spv_pkg::CFG_SAMPLE_LENGTH;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle voice, ignored mode, store ends, one-pass stop at reset settings
    send_produce(8'h7f);
    send_produce(8'h80);
    send_other(MODE_UNUSED);
    send_beat(spv_pkg::MODE_LOAD, 12'hfff, 8'h80, 8'h00);
    send_beat(spv_pkg::MODE_LOAD, 12'h000, 8'h7f, 8'h00);
    send_beat(spv_pkg::MODE_LOAD, 12'h001, 8'hff, 8'h00);
    send_other(spv_pkg::MODE_START);
    send_produce(8'h80);
    send_produce(8'h00);

    // interpolation with wrap at the loop end, saturation both ways, endless loop
    drain_and_settle();
    write_cfg(spv_pkg::CFG_SAMPLE_LENGTH, 32'd2);
    write_cfg(spv_pkg::CFG_START_SPEED, 32'd128);
    write_cfg(spv_pkg::CFG_START_VOLUME, 32'hffff);
    write_cfg(spv_pkg::CFG_LOOP_TOTAL, 32'(spv_pkg::LOOP_FOREVER));
    write_cfg(spv_pkg::CFG_INTERP_ENABLE, 32'd1);
    send_other(spv_pkg::MODE_START);
    send_produce(8'h7f);
    send_produce(8'h80);
    send_produce(8'h00);
    send_produce(8'h80);

    // falling speed ramp drives speed to zero and stops the voice
    drain_and_settle();
    write_cfg(spv_pkg::CFG_RAMP_INTERVAL, 32'd1);
    write_cfg(spv_pkg::CFG_RAMP_SPD_DLT, 32'h8000);
    write_cfg(spv_pkg::CFG_RAMP_VOL_DLT, 32'h7fff);
    write_cfg(spv_pkg::CFG_START_SPEED, 32'hffff);
    write_cfg(spv_pkg::CFG_LOOP_TOTAL, 32'd1);
    send_other(spv_pkg::MODE_START);
    send_produce(8'h01);
    send_produce(8'hfe);

    // zero length, zero speed without ramp, zero loop count
    drain_and_settle();
    write_cfg(spv_pkg::CFG_SAMPLE_LENGTH, 32'd0);
    write_cfg(spv_pkg::CFG_START_SPEED, 32'd0);
    write_cfg(spv_pkg::CFG_RAMP_INTERVAL, 32'd0);
    write_cfg(spv_pkg::CFG_LOOP_TOTAL, 32'd0);
    send_other(spv_pkg::MODE_START);
    send_produce(8'h40);
    send_produce(8'hc0);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain_and_settle();
      quiet_run = (k >= RANDOM_PHASES - 2);
      src_idle_pct = 15 * $urandom_range(0, 3);
      sink_idle_pct = 15 * $urandom_range(0, 3);
      for (int i = 0; i < 8; i++)
        write_cfg(spv_pkg::cfg_idx_e'(i), pick_setting(i, (i == k % 8) ? (k / 8) % 2 : -1));
      run_phase(PHASE_ITEMS, k == 2);
    end

    drain_and_settle();
    if (voice.errors == 0) begin
      $display("[sample_voice_player] OK");
    end else begin
      $display("[sample_voice_player] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/spv_pkg.sv
sv/spv_ram.sv
sv/spv_div.sv
sv/sample_voice_player.sv
sim/testbench.sv
